/* rtl/core/sigmoid_gate_multiply_unit_macros.svh */
// Assertion helpers for the sigmoid gate multiply unit.
`ifndef SIGMOID_GATE_MULTIPLY_UNIT_MACROS_SVH
`define SIGMOID_GATE_MULTIPLY_UNIT_MACROS_SVH

// Same-cycle implication, clocked on aclk, off while aresetn is low.
`define SGMU_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off while aresetn is low.
`define SGMU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/sgmu_pkg.sv */
package sgmu_pkg;

    localparam int DATA_W = 16;
    localparam int MAG_W  = DATA_W + 1;
    localparam int SIG_W  = 16;

    localparam logic OP_FORWARD  = 1'b0;
    localparam logic OP_BACKWARD = 1'b1;

    localparam logic [SIG_W:0] SIG_ONE = 17'h10000;

    localparam logic [MAG_W-1:0] POS_LIMIT = 17'd32767;
    localparam logic [MAG_W-1:0] NEG_LIMIT = 17'd32768;

endpackage

/* rtl/core/sigmoid_gate_multiply_unit.sv */
// Sigmoid gated multiply in signed fixed point. Takes one transfer per clock
// unless the output stalls, passing it through: input register with the clamp and
// ROM address multiply, registered sigmoid ROM read, three parallel products
// (value times sigmoid, sigmoid times its complement, gradient times x), the
// 31 by 31 bit product for the gate gradient with the primary rounding, then
// the final rounding and saturation into the output register. Each stage only
// holds while it is full and the stage after it is stalled, so bubbles close up
// and s_tready stays high while m_tready is high. The sigmoid table is built at
// elaboration and has no fill time after reset.
`include "sigmoid_gate_multiply_unit_macros.svh"

module sigmoid_gate_multiply_unit import sgmu_pkg::*; #(
    parameter int SIG_ENTRIES = 256,
    parameter int FRAC_BITS   = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // x_value [15:0], gate_value [31:16], grad_in [47:32]
    input  logic        s_tuser,   // opcode [0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // primary_out [15:0], gate_grad [31:16]
    output logic        m_tuser,   // saturated [0]
    output logic        m_tlast
);

    localparam int IW  = $clog2(SIG_ENTRIES);
    localparam int NW  = $clog2(SIG_ENTRIES + 1);
    localparam int GW  = (FRAC_BITS + 5 > DATA_W + 1) ? FRAC_BITS + 5 : DATA_W + 1;
    localparam int UW  = FRAC_BITS + 4;
    localparam int PW  = UW + NW + 1;
    localparam int SH  = FRAC_BITS + 32;
    localparam int MW  = 62;

    localparam logic signed [GW-1:0] HALF_POS = GW'(1) <<< (FRAC_BITS + 3);
    localparam logic signed [GW-1:0] HALF_NEG = -HALF_POS;
    localparam logic signed [GW-1:0] HALF_TOP = HALF_POS - GW'(1);
    localparam logic [PW-1:0] IDX_BIAS = PW'(1) << (FRAC_BITS + 3);
    localparam logic [PW-1:0] IDX_MAX  = PW'(SIG_ENTRIES - 1);
    localparam logic [MW-1:0] GG_BIAS  = MW'(1) << (SH - 1);

    typedef logic [SIG_W-1:0] sig_rom_t [SIG_ENTRIES];

    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned dvs);
        longint unsigned quo;
        logic [64:0]     rem;
        quo = 0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, dvs}) begin
                rem    = rem - {1'b0, dvs};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic sig_rom_t build_sig_rom();
        sig_rom_t          rom;
        longint unsigned   n;
        longint unsigned   a;
        longint unsigned   x28;
        longint unsigned   term;
        longint unsigned   pos;
        longint unsigned   sub;
        longint unsigned   e;
        longint unsigned   den;
        longint unsigned   p;
        longint unsigned   kk;
        bit                neg;
        n = 64'(SIG_ENTRIES);
        for (int k = 0; k < SIG_ENTRIES; k++) begin
            kk = 64'(k);
            neg = (16 * kk) < (8 * n);
            a = neg ? (8 * n - 16 * kk) : (16 * kk - 8 * n);
            x28 = udiv64(a << 25, n);
            term = 64'(1) << 31;
            pos = term;
            sub = 0;
            for (int i = 1; i <= 24; i++) begin
                term = udiv64((term * x28) >> 28, 64'(i));
                if (i % 2 == 1) begin
                    sub = sub + term;
                end else begin
                    pos = pos + term;
                end
            end
            e = pos - sub;
            for (int s = 0; s < 3; s++) begin
                e = (e * e + (64'(1) << 30)) >> 31;
            end
            den = (64'(1) << 31) + e;
            p = udiv64((64'(1) << 47) + (den >> 1), den);
            rom[k] = neg ? SIG_W'(64'(SIG_ONE) - p) : SIG_W'(p);
        end
        return rom;
    endfunction

    localparam sig_rom_t SIG_ROM = build_sig_rom();

    // Stage enables: a stage loads when it is empty or the next one loads.
    logic en1, en2, en3, en4, en5;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // stage 1
    logic                    op1_reg, last1_reg, negx1_reg, negg1_reg;
    logic [IW-1:0]           idx1_reg;
    logic [MAG_W-1:0]        magx1_reg, magg1_reg;
    logic signed [DATA_W-1:0] x_in, gate_in, grad_in;
    logic signed [GW-1:0]    g_ext, g_clamp;
    logic [UW-1:0]           u_val;
    logic [PW-1:0]           idx_prod;
    logic [PW-1:0]           idx_full;
    logic [IW-1:0]           idx1_next;
    logic [MAG_W-1:0]        magx1_next, magg1_next;

    // stage 2
    logic                    op2_reg, last2_reg, negx2_reg, negg2_reg;
    logic [SIG_W-1:0]        sig2_reg;
    logic [MAG_W-1:0]        magx2_reg, magg2_reg;

    // stage 3
    logic                    op3_reg, last3_reg, negp3_reg, negq3_reg;
    logic [31:0]             pprod3_reg;
    logic [30:0]             deriv3_reg, mgx3_reg;
    logic [MAG_W-1:0]        magp_sel;
    logic [SIG_W:0]          sig_comp;
    logic [32:0]             pprod_full;
    logic [33:0]             deriv_full;
    logic [33:0]             mgx_full;

    // stage 4
    logic                    op4_reg, last4_reg, negq4_reg, pclip4_reg;
    logic [DATA_W-1:0]       prim4_reg;
    logic [60:0]             m4_reg;
    logic [32:0]             prim_round;
    logic [MAG_W-1:0]        prim_lim;
    logic [MAG_W-1:0]        prim_mag;
    logic                    prim_clip;
    logic [DATA_W-1:0]       prim4_next;
    logic [61:0]             m_full;

    // stage 5
    logic                    op5_reg, last5_reg, sat5_reg;
    logic [DATA_W-1:0]       prim5_reg, gg5_reg;
    logic [MW-1:0]           gg_sum;
    logic [MW-1:0]           gg_round;
    logic [MW-1:0]           gg_lim;
    logic [MW-1:0]           gg_mag;
    logic                    gg_clip;
    logic [DATA_W-1:0]       gg5_next;

    assign en5 = !v5_reg || m_tready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign s_tready = en1;

    always_comb begin
        x_in    = s_tdata[15:0];
        gate_in = s_tdata[31:16];
        grad_in = s_tdata[47:32];
        g_ext   = {{(GW - DATA_W){gate_in[DATA_W-1]}}, gate_in};
        if (g_ext < HALF_NEG) begin
            g_clamp = HALF_NEG;
        end else if (g_ext > HALF_TOP) begin
            g_clamp = HALF_TOP;
        end else begin
            g_clamp = g_ext;
        end
        u_val    = UW'(g_clamp + HALF_POS);
        idx_prod = PW'(u_val) * PW'(SIG_ENTRIES) + IDX_BIAS;
        idx_full = idx_prod >> UW;
        if (idx_full > IDX_MAX) begin
            idx1_next = IW'(IDX_MAX);
        end else begin
            idx1_next = idx_full[IW-1:0];
        end
        magx1_next = x_in[DATA_W-1] ? (MAG_W'(0) - {x_in[DATA_W-1], x_in})
                                    : {1'b0, x_in};
        magg1_next = grad_in[DATA_W-1] ? (MAG_W'(0) - {grad_in[DATA_W-1], grad_in})
                                       : {1'b0, grad_in};
    end

    always_comb begin
        magp_sel   = (op2_reg == OP_BACKWARD) ? magg2_reg : magx2_reg;
        sig_comp   = SIG_ONE - {1'b0, sig2_reg};
        pprod_full = 33'(magp_sel) * 33'(sig2_reg);
        deriv_full = 34'(sig2_reg) * 34'(sig_comp);
        mgx_full   = 34'(magg2_reg) * 34'(magx2_reg);
    end

    always_comb begin
        prim_round = 33'(pprod3_reg) + 33'(17'h08000);
        prim_mag   = prim_round[32:16];
        prim_lim   = negp3_reg ? NEG_LIMIT : POS_LIMIT;
        prim_clip  = prim_mag > prim_lim;
        if (prim_clip) begin
            prim_mag = prim_lim;
        end
        prim4_next = negp3_reg ? DATA_W'(MAG_W'(0) - prim_mag) : prim_mag[DATA_W-1:0];
        m_full     = 62'(mgx3_reg) * 62'(deriv3_reg);
    end

    always_comb begin
        gg_sum   = MW'(m4_reg) + GG_BIAS;
        gg_round = gg_sum >> SH;
        gg_lim   = negq4_reg ? MW'(NEG_LIMIT) : MW'(POS_LIMIT);
        gg_clip  = (op4_reg == OP_BACKWARD) && (gg_round > gg_lim);
        gg_mag   = (gg_round > gg_lim) ? gg_lim : gg_round;
        if (op4_reg == OP_FORWARD) begin
            gg5_next = '0;
        end else if (negq4_reg) begin
            gg5_next = DATA_W'(MW'(0) - gg_mag);
        end else begin
            gg5_next = gg_mag[DATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= s_tvalid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
            if (en4) begin
                v4_reg <= v3_reg;
            end
            if (en5) begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            op1_reg   <= s_tuser;
            last1_reg <= s_tlast;
            idx1_reg  <= idx1_next;
            magx1_reg <= magx1_next;
            magg1_reg <= magg1_next;
            negx1_reg <= x_in[DATA_W-1];
            negg1_reg <= grad_in[DATA_W-1];
        end
        if (en2) begin
            op2_reg   <= op1_reg;
            last2_reg <= last1_reg;
            sig2_reg  <= SIG_ROM[idx1_reg];
            magx2_reg <= magx1_reg;
            magg2_reg <= magg1_reg;
            negx2_reg <= negx1_reg;
            negg2_reg <= negg1_reg;
        end
        if (en3) begin
            op3_reg    <= op2_reg;
            last3_reg  <= last2_reg;
            pprod3_reg <= pprod_full[31:0];
            deriv3_reg <= deriv_full[30:0];
            mgx3_reg   <= mgx_full[30:0];
            negp3_reg  <= (op2_reg == OP_BACKWARD) ? negg2_reg : negx2_reg;
            negq3_reg  <= negg2_reg ^ negx2_reg;
        end
        if (en4) begin
            op4_reg    <= op3_reg;
            last4_reg  <= last3_reg;
            prim4_reg  <= prim4_next;
            pclip4_reg <= prim_clip;
            m4_reg     <= m_full[60:0];
            negq4_reg  <= negq3_reg;
        end
        if (en5) begin
            op5_reg   <= op4_reg;
            last5_reg <= last4_reg;
            prim5_reg <= prim4_reg;
            gg5_reg   <= gg5_next;
            sat5_reg  <= pclip4_reg || gg_clip;
        end
    end

    assign m_tvalid = v5_reg;
    assign m_tdata  = {gg5_reg, prim5_reg};
    assign m_tuser  = sat5_reg;
    assign m_tlast  = last5_reg;

    `SGMU_ASSERT_IMPL(a_fwd_gate_grad_zero, v5_reg && (op5_reg == OP_FORWARD),
        gg5_reg == '0, "forward result carries a non-zero gate gradient")
    `SGMU_ASSERT_IMPL(a_ready_when_drained, m_tready, s_tready,
        "input stalled although the output side is accepting")
    `SGMU_ASSERT_IMPL(a_sat_at_limit, v5_reg && sat5_reg,
        (prim5_reg == 16'h7fff) || (prim5_reg == 16'h8000) ||
        (gg5_reg == 16'h7fff) || (gg5_reg == 16'h8000),
        "saturation flag set with no result at a limit")
    `SGMU_ASSERT_NEXT(a_advance_to_output, v4_reg && en5, v5_reg,
        "item lost between the last two stages")

endmodule

/* tb/sigmoid_gate_multiply_unit_tb.sv */
module sigmoid_gate_multiply_unit_tb import sgmu_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SIZE  = 256;
    localparam int FRAC        = 12;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 20;

    typedef struct {
        logic                     op;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] gate;
        logic signed [DATA_W-1:0] grad;
        logic                     last;
    } element_t;

    typedef struct {
        logic [DATA_W-1:0] primary;
        logic [DATA_W-1:0] gate_grad;
        logic              sat;
        logic              last;
    } gated_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    logic [63:0]   sigmoid_table [TABLE_SIZE];
    gated_result_t pending_results [$];
    gated_result_t want;
    int            mismatch_count = 0;
    int            cycle_count    = 0;
    int            hold_cycles    = 0;
    bit            send_idle_en   = 1'b1;
    bit            recv_idle_en   = 1'b1;

    sigmoid_gate_multiply_unit #(
        .SIG_ENTRIES(TABLE_SIZE),
        .FRAC_BITS  (FRAC)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #2 aclk = ~aclk;

    function automatic void build_sigmoid_table();
        logic [63:0] n, a, x28, term, pos, sub, e, den, p;
        logic        neg;
        n = TABLE_SIZE;
        for (int k = 0; k < TABLE_SIZE; k++) begin
            neg  = (64'(16 * k)) < (8 * n);
            a    = neg ? (8 * n - 64'(16 * k)) : (64'(16 * k) - 8 * n);
            x28  = (a << 25) / n;
            term = 64'd1 << 31;
            pos  = term;
            sub  = '0;
            for (int i = 1; i <= 24; i++) begin
                term = ((term * x28) >> 28) / 64'(i);
                if (i % 2 == 1) begin
                    sub = sub + term;
                end else begin
                    pos = pos + term;
                end
            end
            e = pos - sub;
            for (int s = 0; s < 3; s++) begin
                e = (e * e + (64'd1 << 30)) >> 31;
            end
            den = (64'd1 << 31) + e;
            p   = ((64'd1 << 47) + den / 2) / den;
            sigmoid_table[k] = neg ? (64'(SIG_ONE) - p) : p;
        end
    endfunction

    function automatic logic [63:0] gate_sigmoid(input logic signed [DATA_W-1:0] g);
        longint      half, gv;
        logic [63:0] u, idx;
        half = longint'(8) << FRAC;
        gv   = g;
        if (gv < -half) begin
            gv = -half;
        end
        if (gv > half - 1) begin
            gv = half - 1;
        end
        u   = 64'(gv + half);
        idx = (u * TABLE_SIZE + 64'(half)) / (64'(half) * 2);
        if (idx > TABLE_SIZE - 1) begin
            idx = TABLE_SIZE - 1;
        end
        return sigmoid_table[idx];
    endfunction

    function automatic logic [63:0] magnitude16(input logic signed [DATA_W-1:0] v);
        longint lv;
        lv = v;
        return (lv < 0) ? 64'(-lv) : 64'(lv);
    endfunction

    // returns {clipped, value}
    function automatic logic [DATA_W:0] round_saturate(input logic [63:0] mag,
                                                      input logic neg, input int sh);
        logic [63:0] r, lim;
        logic        clip;
        r    = (mag + (64'd1 << (sh - 1))) >> sh;
        lim  = neg ? 64'(NEG_LIMIT) : 64'(POS_LIMIT);
        clip = 1'b0;
        if (r > lim) begin
            r    = lim;
            clip = 1'b1;
        end
        if (neg) begin
            r = -r;
        end
        return {clip, r[DATA_W-1:0]};
    endfunction

    function automatic gated_result_t predict_gated_product(input element_t el);
        gated_result_t res;
        logic [63:0]   sig, deriv;
        logic [DATA_W:0] pr, gg;
        sig = gate_sigmoid(el.gate);
        gg  = '0;
        if (el.op == OP_FORWARD) begin
            pr = round_saturate(magnitude16(el.x) * sig, el.x < 0, 16);
        end else begin
            pr    = round_saturate(magnitude16(el.grad) * sig, el.grad < 0, 16);
            deriv = sig * (64'(SIG_ONE) - sig);
            gg    = round_saturate(magnitude16(el.grad) * magnitude16(el.x) * deriv,
                                   (el.grad < 0) != (el.x < 0), FRAC + 32);
        end
        res.primary   = pr[DATA_W-1:0];
        res.gate_grad = gg[DATA_W-1:0];
        res.sat       = pr[DATA_W] | gg[DATA_W];
        res.last      = el.last;
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(511)) - 16'd256;
            3:       return $urandom_range(1) ? 16'h8000 + 16'($urandom_range(255))
                                              : 16'h7FFF - 16'($urandom_range(255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic element_t random_element();
        element_t el;
        el.op   = $urandom_range(99) < 55 ? OP_BACKWARD : OP_FORWARD;
        el.x    = pick_value();
        el.gate = pick_value();
        el.grad = pick_value();
        el.last = $urandom_range(15) == 0;
        return el;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        if (mismatch_count < 50) begin
            $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, exp_val);
        end
        mismatch_count++;
    endtask

    task automatic send_element(input element_t el);
        while (send_idle_en && $urandom_range(99) < 19) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {el.grad, el.gate, el.x};
        s_tuser  <= el.op;
        s_tlast  <= el.last;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        pending_results.push_back(predict_gated_product(el));
    endtask

    task automatic send_corner(input logic op, input logic [15:0] x, input logic [15:0] g,
                               input logic [15:0] gr, input logic last);
        element_t el;
        el.op   = op;
        el.x    = x;
        el.gate = g;
        el.grad = gr;
        el.last = last;
        send_element(el);
    endtask

    task automatic test_corner_cases();
        send_corner(OP_FORWARD,  16'h7FFF, 16'h7FFF, 16'h1234, 1'b0);
        send_corner(OP_FORWARD,  16'h8000, 16'h7FFF, 16'h8000, 1'b1);
        send_corner(OP_FORWARD,  16'h8000, 16'h8000, 16'h7FFF, 1'b0);
        send_corner(OP_FORWARD,  16'h7FFF, 16'h0000, 16'hFFFF, 1'b0);
        send_corner(OP_FORWARD,  16'h0001, 16'hFFFF, 16'h0000, 1'b0);
        send_corner(OP_FORWARD,  16'hFFFF, 16'h7FC0, 16'h0001, 1'b1);
        send_corner(OP_FORWARD,  16'h0000, 16'h7F80, 16'h5555, 1'b0);
        send_corner(OP_BACKWARD, 16'h8000, 16'h0000, 16'h8000, 1'b0);
        send_corner(OP_BACKWARD, 16'h7FFF, 16'h0000, 16'h8000, 1'b1);
        send_corner(OP_BACKWARD, 16'h7FFF, 16'h0000, 16'h7FFF, 1'b0);
        send_corner(OP_BACKWARD, 16'h8000, 16'hFFFF, 16'h7FFF, 1'b0);
        send_corner(OP_BACKWARD, 16'h1000, 16'h7FFF, 16'h8000, 1'b0);
        send_corner(OP_BACKWARD, 16'h1000, 16'h8000, 16'h7FFF, 1'b0);
        send_corner(OP_BACKWARD, 16'h0000, 16'h1000, 16'h8000, 1'b1);
        send_corner(OP_BACKWARD, 16'hFFFF, 16'hF000, 16'h0001, 1'b0);
        send_corner(OP_BACKWARD, 16'h4000, 16'h0800, 16'hC000, 1'b0);
        send_corner(OP_BACKWARD, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1);
        send_corner(OP_FORWARD,  16'h5555, 16'hAAAA, 16'h5555, 1'b0);
    endtask

    task automatic test_random_stream(input int count);
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        repeat (count) send_element(random_element());
    endtask

    task automatic test_steady_stream(input int count);
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        repeat (count) send_element(random_element());
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
    endtask

    task automatic test_output_hold(input int count);
        send_idle_en = 1'b0;
        hold_cycles  = 300;
        repeat (count) send_element(random_element());
        send_idle_en = 1'b1;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(recv_idle_en && $urandom_range(99) < 19);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transfer", int'(m_tdata), 0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[15:0] !== want.primary) begin
                    report_mismatch("primary_out", int'(m_tdata[15:0]), int'(want.primary));
                end
                if (m_tdata[31:16] !== want.gate_grad) begin
                    report_mismatch("gate_grad", int'(m_tdata[31:16]), int'(want.gate_grad));
                end
                if (m_tuser !== want.sat) begin
                    report_mismatch("saturated", int'(m_tuser), int'(want.sat));
                end
                if (m_tlast !== want.last) begin
                    report_mismatch("last", int'(m_tlast), int'(want.last));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        build_sigmoid_table();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_corner_cases();
        test_random_stream(700);
        test_steady_stream(220);
        test_output_hold(110);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
